### rtl/picc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Piccolo cipher package
// Round constants, S-box, F-function and half-word splice shared by the
// key schedule and the round pipeline.
// ----------------------------------------------------------------------------
package picc_pkg;

	localparam int unsigned ROUNDS_80  = 25;
	localparam int unsigned ROUNDS_128 = 31;
	localparam int unsigned RK_COUNT   = 2 * ROUNDS_128;
	localparam logic [31:0] CON_BASE_80  = 32'h0F1E2D3C;
	localparam logic [31:0] CON_BASE_128 = 32'h6547A98B;

	localparam logic [1:0] REG_KEY_UPPER = 2'd0;
	localparam logic [1:0] REG_KEY_LOWER = 2'd1;
	localparam logic [1:0] REG_KEY_MODE  = 2'd2;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [15:0] word_t;
	typedef word_t rk_arr_t [RK_COUNT];

	typedef struct packed {
		word_t wk0;
		word_t wk1;
		word_t wk2;
		word_t wk3;
		logic  wide;
	} wkeys_t;

	function automatic logic [3:0] sbox(input logic [3:0] a);
		logic [3:0] r;
		case (a)
			4'h0: r = 4'he;
			4'h1: r = 4'h4;
			4'h2: r = 4'hb;
			4'h3: r = 4'h2;
			4'h4: r = 4'h3;
			4'h5: r = 4'h8;
			4'h6: r = 4'h0;
			4'h7: r = 4'h9;
			4'h8: r = 4'h1;
			4'h9: r = 4'ha;
			4'ha: r = 4'h7;
			4'hb: r = 4'hf;
			4'hc: r = 4'h6;
			4'hd: r = 4'hc;
			4'he: r = 4'h5;
			default: r = 4'hd;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] mul2(input logic [3:0] a);
		return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
	endfunction

	function automatic logic [3:0] mix_row(input logic [3:0] a, input logic [3:0] b,
		input logic [3:0] c, input logic [3:0] d);
		return mul2(a) ^ mul2(b) ^ b ^ c ^ d;
	endfunction

	function automatic word_t f_func(input word_t x);
		logic [3:0] s0, s1, s2, s3;
		s0 = sbox(x[15:12]);
		s1 = sbox(x[11:8]);
		s2 = sbox(x[7:4]);
		s3 = sbox(x[3:0]);
		return {sbox(mix_row(s0, s1, s2, s3)), sbox(mix_row(s1, s2, s3, s0)),
			sbox(mix_row(s2, s3, s0, s1)), sbox(mix_row(s3, s0, s1, s2))};
	endfunction

	function automatic word_t hi_lo(input word_t a, input word_t b);
		return {a[15:8], b[7:0]};
	endfunction

	// Round constant pair for round i (from 0).
	function automatic logic [31:0] con(input int unsigned i, input logic wide);
		logic [31:0] c;
		c = 32'(i + 1);
		return (c << 27) ^ (c << 17) ^ (c << 10) ^ c ^ (wide ? CON_BASE_128 : CON_BASE_80);
	endfunction

endpackage
`default_nettype wire

### rtl/lightweight_64bit_block_cipher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Piccolo 64-bit block cipher, fully unrolled pipeline
// Encrypts or decrypts one 64-bit block per cycle, while the output is not stalled,
// under an 80-bit or 128-bit key held in APB registers.
// ----------------------------------------------------------------------------
//  Channel  | Signals                              | Beat accepted when
//  ---------+--------------------------------------+--------------------------
//  input    | in_valid, in_ready, block_in, opcode | in_valid && in_ready
//  output   | out_valid, out_ready, block_out      | out_valid && out_ready
//  config   | psel, penable, pwrite, paddr, pwdata | psel && penable && pwrite
//
// One beat may enter every cycle unless the pipeline is frozen. A block spends
// one stage in the input whitening stage, one in each of the 31 round stages
// and one in the output register; 80-bit blocks (25 rounds) pass the last six
// round stages unchanged. The whole pipeline advances together and freezes
// when the output register is full and not taken, so a stall loses nothing.
// Reset clears the valid bits and the key registers only.
// ----------------------------------------------------------------------------
module lightweight_64bit_block_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] block_in,
	input  wire logic        opcode,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      block_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import picc_pkg::*;

	localparam int unsigned NS = ROUNDS_128;

	logic [63:0] key_upper_q, key_lower_q;
	logic        key_mode_q;
	wkeys_t      wkeys;
	rk_arr_t     rk;
	logic        advance;

	// Register file: registers at byte offsets 0, 8 and 16.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
			key_mode_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				REG_KEY_UPPER: key_upper_q <= pwdata;
				REG_KEY_LOWER: key_lower_q <= pwdata;
				REG_KEY_MODE:  key_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_KEY_UPPER: prdata = key_upper_q;
			REG_KEY_LOWER: prdata = key_lower_q;
			REG_KEY_MODE:  prdata = {63'd0, key_mode_q};
			default:       prdata = '0;
		endcase
	end

	picc_keysched u_keysched (
		.key_upper (key_upper_q),
		.key_lower (key_lower_q),
		.key_mode  (key_mode_q),
		.wkeys     (wkeys),
		.rk        (rk)
	);

	// Whole pipeline moves when the output register is free or being taken.
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// Stage 0: input whitening. Direction and mode travel with the block; the
	// key is read here and in each round, and the user must change it only when idle: the block does not enforce this.
	logic [63:0] blk_s0;
	logic        dec_s0, wide_s0, vld_s0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else if (advance) vld_s0 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			dec_s0  <= opcode;
			wide_s0 <= wkeys.wide;
			blk_s0  <= {block_in[63:48] ^ (opcode ? wkeys.wk2 : wkeys.wk0), block_in[47:32],
				block_in[31:16] ^ (opcode ? wkeys.wk3 : wkeys.wk1), block_in[15:0]};
		end
	end

	// Round stages.
	logic [63:0] blk_r [NS+1];
	logic        dec_r [NS+1];
	logic        wide_r [NS+1];
	logic        vld_r [NS+1];
	assign blk_r[0]  = blk_s0;
	assign dec_r[0]  = dec_s0;
	assign wide_r[0] = wide_s0;
	assign vld_r[0]  = vld_s0;

	for (genvar g = 0; g < NS; g++) begin : g_round
		// Decryption round key positions for the 80-bit schedule; stages past
		// its last round never use them.
		localparam int unsigned DA80 = (g < ROUNDS_80) ?
			((g % 2 == 0) ? 2 * ROUNDS_80 - 2 * g - 2 : 2 * ROUNDS_80 - 2 * g - 1) : 0;
		localparam int unsigned DB80 = (g < ROUNDS_80) ?
			((g % 2 == 0) ? 2 * ROUNDS_80 - 2 * g - 1 : 2 * ROUNDS_80 - 2 * g - 2) : 0;
		logic [63:0] nxt;
		always_comb begin
			word_t x0, x1, x2, x3, rka, rkb;
			int unsigned r;
			r  = wide_r[g] ? ROUNDS_128 : ROUNDS_80;
			x0 = blk_r[g][63:48]; x1 = blk_r[g][47:32];
			x2 = blk_r[g][31:16]; x3 = blk_r[g][15:0];
			if (!dec_r[g]) begin
				rka = rk[2 * g]; rkb = rk[2 * g + 1];
			end else if (wide_r[g]) begin
				rka = rk[(g % 2 == 0) ? 2 * ROUNDS_128 - 2 * g - 2 : 2 * ROUNDS_128 - 2 * g - 1];
				rkb = rk[(g % 2 == 0) ? 2 * ROUNDS_128 - 2 * g - 1 : 2 * ROUNDS_128 - 2 * g - 2];
			end else if (g < ROUNDS_80) begin
				rka = rk[DA80];
				rkb = rk[DB80];
			end else begin
				rka = '0; rkb = '0;
			end
			x1 = x1 ^ f_func(x0) ^ rka;
			x3 = x3 ^ f_func(x2) ^ rkb;
			if (g >= r) begin
				nxt = blk_r[g];
			end else if (g == r - 1) begin
				nxt = {x0, x1, x2, x3};
			end else begin
				nxt = {hi_lo(x1, x3), hi_lo(x2, x0), hi_lo(x3, x1), hi_lo(x0, x2)};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_r[g+1] <= 1'b0;
			else if (advance) vld_r[g+1] <= vld_r[g];
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				blk_r[g+1]  <= nxt;
				dec_r[g+1]  <= dec_r[g];
				wide_r[g+1] <= wide_r[g];
			end
		end
	end

	// Output whitening into the output register.
	logic [63:0] out_q;
	logic        out_vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (advance) out_vld_q <= vld_r[NS];
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= {blk_r[NS][63:48] ^ (dec_r[NS] ? wkeys.wk0 : wkeys.wk2), blk_r[NS][47:32],
				blk_r[NS][31:16] ^ (dec_r[NS] ? wkeys.wk1 : wkeys.wk3), blk_r[NS][15:0]};
		end
	end
	assign out_valid = out_vld_q;
	assign block_out = out_q;

endmodule
`default_nettype wire

### rtl/picc_keysched.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Piccolo key schedule
// Expands the stored key into whitening keys and the round key table.
// ----------------------------------------------------------------------------
module picc_keysched (
	input  wire logic [63:0]      key_upper,
	input  wire logic [63:0]      key_lower,
	input  wire logic             key_mode,
	output picc_pkg::wkeys_t      wkeys,
	output picc_pkg::rk_arr_t     rk
);
	import picc_pkg::*;

	word_t k [8];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			k[i]     = key_upper[48 - 16 * i +: 16];
			k[i + 4] = key_lower[48 - 16 * i +: 16];
		end
	end

	always_comb begin
		wkeys.wide = key_mode;
		wkeys.wk0  = hi_lo(k[0], k[1]);
		wkeys.wk1  = hi_lo(k[1], k[0]);
		wkeys.wk2  = key_mode ? hi_lo(k[4], k[7]) : hi_lo(k[4], k[3]);
		wkeys.wk3  = key_mode ? hi_lo(k[7], k[4]) : hi_lo(k[3], k[4]);
	end

	// The 128-bit schedule permutes the key words every eight round keys; the
	// permutation is fixed, so each round key index maps to a constant source.
	always_comb begin
		word_t kk [8];
		word_t t [8];
		logic [31:0] cw;
		logic [2:0] m, sel;
		for (int i = 0; i < 8; i++) begin
			kk[i] = k[i];
			t[i]  = k[i];
		end
		for (int j = 0; j < RK_COUNT; j++) begin
			cw  = con(unsigned'(j / 2), key_mode);
			sel = 3'((j + 2) % 8);
			if (sel == 3'd0) begin
				t[0] = kk[2]; t[1] = kk[1]; t[2] = kk[6]; t[3] = kk[7];
				t[4] = kk[0]; t[5] = kk[3]; t[6] = kk[4]; t[7] = kk[5];
				for (int i = 0; i < 8; i++) kk[i] = t[i];
			end
			m = 3'((j / 2) % 5);
			if (key_mode) begin
				rk[j] = (j % 2 == 0 ? cw[31:16] : cw[15:0]) ^ kk[sel];
			end else if (m == 3'd0 || m == 3'd2) begin
				rk[j] = (j % 2 == 0) ? cw[31:16] ^ k[2] : cw[15:0] ^ k[3];
			end else if (m == 3'd1 || m == 3'd4) begin
				rk[j] = (j % 2 == 0) ? cw[31:16] ^ k[0] : cw[15:0] ^ k[1];
			end else begin
				rk[j] = (j % 2 == 0 ? cw[31:16] : cw[15:0]) ^ k[4];
			end
		end
	end

endmodule
`default_nettype wire

### rtl/picc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Piccolo port checker
// Watches the ports of the cipher for handshake and flow mistakes.
// ----------------------------------------------------------------------------
module picc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] block_out,
	input wire logic        pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_out))
		else $error("result beat dropped or changed while stalled");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline stalled");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind lightweight_64bit_block_cipher picc_checker u_picc_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .block_out(block_out),
	.pready(pready)
);
`default_nettype wire

### sim/piccolo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piccolo result checker
// Watches the block and result channels and the register port, keeps its own
// copy of the key registers, computes the expected block for every accepted
// beat and compares it with the results in order.
// ----------------------------------------------------------------------------
module piccolo_checker
	import picc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [63:0] block_in,
	input  wire logic        opcode,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] block_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending,
	output int               results_seen
);

	logic [63:0] key_hi, key_lo;
	logic        wide_key;
	logic [63:0] expected_blocks [$];

	localparam logic [3:0] SUBST [16] = '{4'he, 4'h4, 4'hb, 4'h2, 4'h3, 4'h8, 4'h0, 4'h9,
		4'h1, 4'ha, 4'h7, 4'hf, 4'h6, 4'hc, 4'h5, 4'hd};

	function automatic logic [3:0] times2(logic [3:0] a);
		return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
	endfunction

	function automatic logic [3:0] diffuse(logic [3:0] a, logic [3:0] b, logic [3:0] c,
		logic [3:0] d);
		return times2(a) ^ times2(b) ^ b ^ c ^ d;
	endfunction

	function automatic logic [15:0] round_fn(logic [15:0] x);
		logic [3:0] s [4];
		logic [15:0] y;
		for (int n = 0; n < 4; n++) s[n] = SUBST[x[15-4*n -: 4]];
		for (int n = 0; n < 4; n++)
			y[15-4*n -: 4] = SUBST[diffuse(s[n], s[(n+1)%4], s[(n+2)%4], s[(n+3)%4])];
		return y;
	endfunction

	function automatic logic [15:0] splice(logic [15:0] a, logic [15:0] b);
		return {a[15:8], b[7:0]};
	endfunction

	function automatic logic [63:0] cipher_block(logic [63:0] blk, logic dir);
		logic [15:0] k [8], t [8], wk [4], rk [62], x [4], y [4], ra, rb, w0, w1;
		logic [31:0] cst, cnt;
		int nr, m, sel;
		for (int n = 0; n < 4; n++) begin
			k[n] = key_hi[63-16*n -: 16];
			k[n+4] = key_lo[63-16*n -: 16];
		end
		nr = wide_key ? ROUNDS_128 : ROUNDS_80;
		wk[0] = splice(k[0], k[1]);
		wk[1] = splice(k[1], k[0]);
		wk[2] = wide_key ? splice(k[4], k[7]) : splice(k[4], k[3]);
		wk[3] = wide_key ? splice(k[7], k[4]) : splice(k[3], k[4]);
		for (int n = 0; n < nr; n++) begin
			cnt = n + 1;
			cst = (cnt << 27) ^ (cnt << 17) ^ (cnt << 10) ^ cnt ^
				(wide_key ? 32'h6547A98B : 32'h0F1E2D3C);
			rk[2*n] = cst[31:16];
			rk[2*n+1] = cst[15:0];
			if (!wide_key) begin
				m = n % 5;
				if (m == 0 || m == 2) begin
					rk[2*n] ^= k[2]; rk[2*n+1] ^= k[3];
				end else if (m == 1 || m == 4) begin
					rk[2*n] ^= k[0]; rk[2*n+1] ^= k[1];
				end else begin
					rk[2*n] ^= k[4]; rk[2*n+1] ^= k[4];
				end
			end
		end
		if (wide_key) begin
			for (int j = 0; j < 2*nr; j++) begin
				sel = (j + 2) & 7;
				if (sel == 0) begin
					t = '{k[2], k[1], k[6], k[7], k[0], k[3], k[4], k[5]};
					k = t;
				end
				rk[j] ^= k[sel];
			end
		end
		w0 = dir == OP_DECRYPT ? wk[2] : wk[0];
		w1 = dir == OP_DECRYPT ? wk[3] : wk[1];
		for (int n = 0; n < 4; n++) x[n] = blk[63-16*n -: 16];
		x[0] ^= w0;
		x[2] ^= w1;
		for (int n = 0; n < nr; n++) begin
			if (dir == OP_ENCRYPT) begin
				ra = rk[2*n]; rb = rk[2*n+1];
			end else if (n % 2 == 0) begin
				ra = rk[2*nr-2*n-2]; rb = rk[2*nr-2*n-1];
			end else begin
				ra = rk[2*nr-2*n-1]; rb = rk[2*nr-2*n-2];
			end
			x[1] ^= round_fn(x[0]) ^ ra;
			x[3] ^= round_fn(x[2]) ^ rb;
			if (n < nr - 1) begin
				y = '{splice(x[1], x[3]), splice(x[2], x[0]), splice(x[3], x[1]),
					splice(x[0], x[2])};
				x = y;
			end
		end
		x[0] ^= dir == OP_DECRYPT ? wk[0] : wk[2];
		x[2] ^= dir == OP_DECRYPT ? wk[1] : wk[3];
		return {x[0], x[1], x[2], x[3]};
	endfunction

	assign pending = expected_blocks.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi <= '0;
			key_lo <= '0;
			wide_key <= 1'b0;
			errors = 0;
			results_seen = 0;
			expected_blocks.delete();
		end else begin
			if (in_valid && in_ready) expected_blocks.push_back(cipher_block(block_in, opcode));
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_blocks.size() == 0) begin
					$error("block_out: unexpected result %h", block_out);
					errors++;
				end else begin
					if (block_out !== expected_blocks[0]) begin
						$error("block_out: expected %h, actual %h", expected_blocks[0], block_out);
						errors++;
					end
					void'(expected_blocks.pop_front());
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_KEY_UPPER: key_hi <= pwdata;
					REG_KEY_LOWER: key_lo <= pwdata;
					REG_KEY_MODE:  wide_key <= pwdata[0];
					default: ;
				endcase
			end
		end
	end

endmodule

### sim/lightweight_64bit_block_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piccolo cipher testbench
// Drives blocks under a series of keys and both key lengths, with random
// bursts on the block channel and random stalls on the result channel. The
// checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module lightweight_64bit_block_cipher_test;
	import picc_pkg::*;

	// The watchdog allows far more than the longest gap or stall could ever
	// leave the channels idle.
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [63:0] block_in = '0;
	logic        opcode = OP_ENCRYPT;
	logic        out_ready = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	wire         in_ready, out_valid, pready;
	wire [63:0]  block_out, prdata;
	int          errors, pending, results_seen;
	int          idle_cycles = 0;
	int          beats_sent = 0;
	bit          stall_enable = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	lightweight_64bit_block_cipher u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.block_in(block_in), .opcode(opcode), .out_valid(out_valid), .out_ready(out_ready),
		.block_out(block_out), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	piccolo_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.block_in(block_in), .opcode(opcode), .out_valid(out_valid), .out_ready(out_ready),
		.block_out(block_out), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .errors(errors),
		.pending(pending), .results_seen(results_seen)
	);

	// The receiver stalls on a pattern of its own: random phases, and long
	// stretches of constant readiness whenever stalls are switched off.
	always @(posedge clk) begin
		if (!stall_enable) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// The watchdog counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Register write in a setup and an access phase; the register takes the value on the access edge.
	task automatic write_register(input logic [1:0] index, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {index, 3'b000}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Offers one beat and holds it until the block takes it.
	task automatic send_block(input logic [63:0] value, input logic dir);
		in_valid <= 1'b1;
		block_in <= value;
		opcode <= dir;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	// Lowers valid and waits a random gap before the next burst.
	task automatic burst_gap();
		int gap;
		gap = $urandom_range(1, 6);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Waits until every expected result has come, then lets the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_traffic(input int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			for (int n = 0; n < burst && count > 0; n++, count--)
				send_block({$urandom, $urandom}, $urandom_range(0, 1));
			if ($urandom_range(0, 2) != 0) burst_gap();
		end
	endtask

	initial begin
		logic [63:0] key_a, key_b;
		logic [63:0] extremes [4];
		extremes = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the reset key, then the published test key in both
		// modes, with extreme blocks in both directions.
		foreach (extremes[n]) send_block(extremes[n], OP_ENCRYPT);
		foreach (extremes[n]) send_block(extremes[n], OP_DECRYPT);
		drain();
		write_register(REG_KEY_UPPER, 64'h0011_2233_4455_6677);
		write_register(REG_KEY_LOWER, 64'h8899_FFFF_FFFF_FFFF);
		send_block(64'h0123_4567_89AB_CDEF, OP_ENCRYPT);
		send_block(64'h0123_4567_89AB_CDEF, OP_DECRYPT);
		drain();
		write_register(REG_KEY_LOWER, 64'h8899_AABB_CCDD_EEFF);
		write_register(REG_KEY_MODE, 64'h1);
		send_block(64'h0123_4567_89AB_CDEF, OP_ENCRYPT);
		send_block(64'h0123_4567_89AB_CDEF, OP_DECRYPT);
		foreach (extremes[n]) send_block(extremes[n], n[0]);
		// A pause until every result is back, with the receiver never stalling.
		stall_enable = 1'b0;
		drain();
		write_register(REG_KEY_UPPER, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(REG_KEY_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block(64'h0, OP_ENCRYPT);
		send_block(64'hFFFF_FFFF_FFFF_FFFF, OP_DECRYPT);
		drain();
		stall_enable = 1'b1;

		// Random part: eight phases, each under a fresh random key, with the
		// mode alternating so that both key lengths see heavy traffic.
		for (int phase = 0; phase < 8; phase++) begin
			key_a = {$urandom, $urandom};
			key_b = {$urandom, $urandom};
			write_register(REG_KEY_UPPER, key_a);
			write_register(REG_KEY_LOWER, key_b);
			write_register(REG_KEY_MODE, {63'h0, phase[0]});
			random_traffic(250);
			drain();
		end

		$display("Sent %0d blocks, checked %0d results, under 80-bit and 128-bit keys.",
			beats_sent, results_seen);
		$display("Directed keys and extreme blocks in both directions, then random bursts.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
